// ===== rtl/core/pzb_pkg.sv =====
package pzb_pkg;

	localparam int COORD_W = 16;
	localparam int COEF_W  = 18;
	localparam int ROWC_W  = 3 * COEF_W;
	localparam int DEPTH_W = 20;
	// One pixel word: mark bit on top of the depth.
	localparam int PIX_W   = DEPTH_W + 1;
	// Column and row before the range check, signed.
	localparam int POS_W   = 17;

	localparam int MAX_COLS_DEF = 256;
	localparam int MAX_ROWS_DEF = 256;

	localparam logic [7:0] CENTER_COL_RST   = 8'd114;
	localparam logic [7:0] CENTER_ROW_RST   = 8'd101;
	localparam logic [8:0] PLANE_WIDTH_RST  = 9'd229;
	localparam logic [8:0] PLANE_HEIGHT_RST = 9'd203;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_PROJECT = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		CFG_ROW0     = 3'd0,
		CFG_ROW1     = 3'd1,
		CFG_ROW2     = 3'd2,
		CFG_CENTER_C = 3'd3,
		CFG_CENTER_R = 3'd4,
		CFG_PLANE_W  = 3'd5,
		CFG_PLANE_H  = 3'd6
	} cfg_idx_t;

	// Transformed item as it leaves the arithmetic pipeline.
	typedef struct packed {
		logic                      vld;
		logic [1:0]                op;
		logic signed [POS_W-1:0]   col;
		logic signed [POS_W-1:0]   row;
		logic signed [DEPTH_W-1:0] depth;
		logic [7:0]                rrow;
		logic [7:0]                rcol;
	} xf_t;

endpackage

// ===== rtl/core/pzb_if.sv =====
interface pzb_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [15:0] pt_x;
	logic signed [15:0] pt_y;
	logic signed [15:0] pt_z;
	logic [7:0]         read_row;
	logic [7:0]         read_col;

	modport source (output valid, op, pt_x, pt_y, pt_z, read_row, read_col, input ready);
	modport sink (input valid, op, pt_x, pt_y, pt_z, read_row, read_col, output ready);
endinterface

interface pzb_rsp_if;
	logic               valid;
	logic               ready;
	logic               stored;
	logic [7:0]         hit_col;
	logic [7:0]         hit_row;
	logic               pixel_marked;
	logic signed [19:0] pixel_depth;

	modport source (output valid, stored, hit_col, hit_row, pixel_marked, pixel_depth,
		input ready);
	modport sink (input valid, stored, hit_col, hit_row, pixel_marked, pixel_depth,
		output ready);
endinterface

// ===== rtl/core/pzb_transform.sv =====
module pzb_transform (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 in_vld,
	input  logic [1:0]                           op,
	input  logic signed [pzb_pkg::COORD_W-1:0]   pt_x,
	input  logic signed [pzb_pkg::COORD_W-1:0]   pt_y,
	input  logic signed [pzb_pkg::COORD_W-1:0]   pt_z,
	input  logic [7:0]                           read_row,
	input  logic [7:0]                           read_col,
	input  logic [pzb_pkg::ROWC_W-1:0]           row0_coeffs,
	input  logic [pzb_pkg::ROWC_W-1:0]           row1_coeffs,
	input  logic [pzb_pkg::ROWC_W-1:0]           row2_coeffs,
	input  logic [7:0]                           center_col,
	input  logic [7:0]                           center_row,
	output pzb_pkg::xf_t                         xf
);

	localparam int PROD_W = pzb_pkg::COEF_W + pzb_pkg::COORD_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int PW     = pzb_pkg::POS_W;
	localparam int DW     = pzb_pkg::DEPTH_W;

	function automatic logic signed [pzb_pkg::COEF_W-1:0] coef(
		input logic [pzb_pkg::ROWC_W-1:0] r,
		input int                         j
	);
		coef = r[pzb_pkg::COEF_W*j +: pzb_pkg::COEF_W];
	endfunction

	// Stage 1: captured item.
	logic                                vld_s1;
	logic [1:0]                          op_s1;
	logic signed [pzb_pkg::COORD_W-1:0]  pt_s1 [3];
	logic [7:0]                          rr_s1, rc_s1;

	// Stage 2: the nine products.
	logic                                vld_s2;
	logic [1:0]                          op_s2;
	logic [7:0]                          rr_s2, rc_s2;
	logic signed [PROD_W-1:0]            prod_s2 [3][3];
	logic signed [PROD_W-1:0]            prod_c  [3][3];
	logic [pzb_pkg::ROWC_W-1:0]          mat [3];

	// Stage 3: the three dot products, 20 fraction bits.
	logic                                vld_s3;
	logic [1:0]                          op_s3;
	logic [7:0]                          rr_s3, rc_s3;
	logic signed [SUM_W-1:0]             sum_s3 [3];
	logic signed [SUM_W-1:0]             sum_c  [3];

	// Stage 4 rounding.
	logic signed [SUM_W-21:0]            q_col, q_row;
	logic signed [SUM_W-17:0]            q_dep;
	logic                                inc_col, inc_row, inc_dep;
	logic                                vld_s4;
	pzb_pkg::xf_t                        xf_c, xf_s4;

	assign mat[0] = row0_coeffs;
	assign mat[1] = row1_coeffs;
	assign mat[2] = row2_coeffs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= op;
			pt_s1[0] <= pt_x;
			pt_s1[1] <= pt_y;
			pt_s1[2] <= pt_z;
			rr_s1    <= read_row;
			rc_s1    <= read_col;
			op_s2    <= op_s1;
			rr_s2    <= rr_s1;
			rc_s2    <= rc_s1;
			prod_s2  <= prod_c;
			op_s3    <= op_s2;
			rr_s3    <= rr_s2;
			rc_s3    <= rc_s2;
			sum_s3   <= sum_c;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_c[i][j] = coef(mat[i], j) * pt_s1[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = SUM_W'(prod_s2[i][0]) + SUM_W'(prod_s2[i][1]) + SUM_W'(prod_s2[i][2]);
		end
	end

	// Floor by arithmetic shift, then round up past half, or at exactly half toward even.
	always_comb begin
		q_col   = sum_s3[0][SUM_W-1:20];
		inc_col = sum_s3[0][19] && ((|sum_s3[0][18:0]) || sum_s3[0][20]);
		q_row   = sum_s3[1][SUM_W-1:20];
		inc_row = sum_s3[1][19] && ((|sum_s3[1][18:0]) || sum_s3[1][20]);
		q_dep   = sum_s3[2][SUM_W-1:16];
		inc_dep = sum_s3[2][15] && ((|sum_s3[2][14:0]) || sum_s3[2][16]);

		xf_c.vld   = vld_s3;
		xf_c.op    = op_s3;
		xf_c.col   = $signed({(PW-8)'(0), center_col}) + PW'(q_col)
			+ $signed({(PW-1)'(0), inc_col});
		xf_c.row   = $signed({(PW-8)'(0), center_row}) - PW'(q_row)
			- $signed({(PW-1)'(0), inc_row});
		xf_c.depth = DW'(q_dep) + $signed({(DW-1)'(0), inc_dep});
		xf_c.rrow  = rr_s3;
		xf_c.rcol  = rc_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= xf_c.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xf_s4 <= xf_c;
		end
	end

	// The valid bit comes from the reset flop; the payload flops have no reset.
	always_comb begin
		xf     = xf_s4;
		xf.vld = vld_s4;
	end

endmodule

// ===== rtl/core/pzb_pixel_mem.sv =====
module pzb_pixel_mem #(
	parameter int MAX_COLS = pzb_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = pzb_pkg::MAX_ROWS_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                rd_en,
	input  logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0]        rd_addr,
	output logic [pzb_pkg::PIX_W-1:0]                           rd_data,
	input  logic                                                wr_en,
	input  logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0]        wr_addr,
	input  logic [pzb_pkg::PIX_W-1:0]                           wr_data,
	input  logic                                                sweep_start,
	output logic                                                busy
);

	localparam int AW    = $clog2(MAX_COLS) + $clog2(MAX_ROWS);
	localparam int DEPTH = 2 ** AW;
	localparam int W     = pzb_pkg::PIX_W;

	logic [W-1:0]  mem [DEPTH];
	logic [W-1:0]  data_q;
	logic          sweep_q;
	logic [AW-1:0] cnt_q;
	logic          we;
	logic [AW-1:0] wa;
	logic [W-1:0]  wd;

	// The sweep writes an all-zero word (mark clear) to every entry, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= 1'b1;
			cnt_q   <= '0;
		end else if (sweep_start) begin
			sweep_q <= 1'b1;
			cnt_q   <= '0;
		end else if (sweep_q) begin
			if (cnt_q == {AW{1'b1}}) begin
				sweep_q <= 1'b0;
			end
			cnt_q <= cnt_q + AW'(1);
		end
	end

	assign we = sweep_q || wr_en;
	assign wa = sweep_q ? cnt_q : wr_addr;
	assign wd = sweep_q ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	assign rd_data = data_q;
	assign busy    = sweep_q;

endmodule

// ===== rtl/core/point_zbuffer_projection.sv =====
// Channel  Beat               Direction  Handshake
// cmd      op, point, pixel   in         valid/ready
// rsp      result fields      out        valid/ready
// cfg      register write     in         cfg_we, no ready
//
// A beat accepted on cmd passes the stage 1 to 5 registers and the output register
// before it shows up on rsp; one beat per cycle is taken while rsp keeps draining and
// no clear is pending or sweeping. Every stage moves together and holds when rsp stalls.
// A clear lets the pipe drain, then sweeps all 2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) pixel
// memory entries (65536 by default) one per cycle, with cmd not ready, as also right after reset.
module point_zbuffer_projection #(
	parameter int MAX_COLS = pzb_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = pzb_pkg::MAX_ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	pzb_cmd_if.sink                        cmd,
	pzb_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_idx,
	input  logic [pzb_pkg::ROWC_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int AW = CW + RW;
	localparam int DW = pzb_pkg::DEPTH_W;
	localparam int PW = pzb_pkg::POS_W;

	// Configuration registers.
	logic [pzb_pkg::ROWC_W-1:0] row0_q, row1_q, row2_q;
	logic [7:0]                 center_col_q, center_row_q;
	logic [8:0]                 plane_w_q, plane_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q       <= '0;
			row1_q       <= '0;
			row2_q       <= '0;
			center_col_q <= pzb_pkg::CENTER_COL_RST;
			center_row_q <= pzb_pkg::CENTER_ROW_RST;
			plane_w_q    <= pzb_pkg::PLANE_WIDTH_RST;
			plane_h_q    <= pzb_pkg::PLANE_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pzb_pkg::CFG_ROW0:     row0_q       <= cfg_data;
				pzb_pkg::CFG_ROW1:     row1_q       <= cfg_data;
				pzb_pkg::CFG_ROW2:     row2_q       <= cfg_data;
				pzb_pkg::CFG_CENTER_C: center_col_q <= cfg_data[7:0];
				pzb_pkg::CFG_CENTER_R: center_row_q <= cfg_data[7:0];
				pzb_pkg::CFG_PLANE_W:  plane_w_q    <= cfg_data[8:0];
				pzb_pkg::CFG_PLANE_H:  plane_h_q    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	logic         adv;
	logic         busy;
	logic         clr_pend_q;
	logic         accept;
	pzb_pkg::xf_t xf;

	// Output register.
	logic          out_vld_q;
	logic          stored_q;
	logic [7:0]    hit_col_q, hit_row_q;
	logic          marked_q;
	logic [DW-1:0] pdepth_q;

	assign adv       = !out_vld_q || rsp.ready;
	assign cmd.ready = adv && !clr_pend_q && !busy;
	assign accept    = cmd.valid && cmd.ready;

	pzb_transform u_xf (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_vld      (accept),
		.op          (cmd.op),
		.pt_x        (cmd.pt_x),
		.pt_y        (cmd.pt_y),
		.pt_z        (cmd.pt_z),
		.read_row    (cmd.read_row),
		.read_col    (cmd.read_col),
		.row0_coeffs (row0_q),
		.row1_coeffs (row1_q),
		.row2_coeffs (row2_q),
		.center_col  (center_col_q),
		.center_row  (center_row_q),
		.xf          (xf)
	);

	// Stage 4: range check and memory address.
	logic [8:0]    w_eff, h_eff;
	logic          pt_in, rd_in, in_rng_c;
	logic [AW-1:0] addr_c;

	assign w_eff = ({23'b0, plane_w_q} > MAX_COLS) ? 9'(MAX_COLS) : plane_w_q;
	assign h_eff = ({23'b0, plane_h_q} > MAX_ROWS) ? 9'(MAX_ROWS) : plane_h_q;

	always_comb begin
		pt_in = !xf.col[PW-1] && (xf.col[PW-2:0] < (PW-1)'(w_eff))
			&& !xf.row[PW-1] && (xf.row[PW-2:0] < (PW-1)'(h_eff));
		rd_in = ({1'b0, xf.rrow} < h_eff) && ({1'b0, xf.rcol} < w_eff);
		if (xf.op == pzb_pkg::OP_READ) begin
			addr_c   = {RW'(xf.rrow), CW'(xf.rcol)};
			in_rng_c = rd_in;
		end else begin
			addr_c   = {xf.row[RW-1:0], xf.col[CW-1:0]};
			in_rng_c = (xf.op == pzb_pkg::OP_PROJECT) && pt_in;
		end
	end

	// Stage 5: read data is back; compare and write.
	logic                      vld_s5;
	logic [1:0]                op_s5;
	logic                      in_rng_s5;
	logic [AW-1:0]             addr_s5;
	logic [7:0]                col_s5, row_s5;
	logic signed [DW-1:0]      depth_s5;
	logic                      fwd_hit_s5;
	logic [pzb_pkg::PIX_W-1:0] fwd_data_s5;
	logic [pzb_pkg::PIX_W-1:0] rd_data;
	logic [pzb_pkg::PIX_W-1:0] cur;
	logic                      cur_mark;
	logic signed [DW-1:0]      cur_depth;
	logic                      store;
	logic                      wr_en;
	logic [pzb_pkg::PIX_W-1:0] wr_data;
	logic                      sweep_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5     <= 1'b0;
			fwd_hit_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5     <= xf.vld;
			// The memory returns the old word when the entry is written in the read cycle.
			fwd_hit_s5 <= wr_en && (addr_s5 == addr_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s5       <= xf.op;
			in_rng_s5   <= in_rng_c;
			addr_s5     <= addr_c;
			col_s5      <= xf.col[7:0];
			row_s5      <= xf.row[7:0];
			depth_s5    <= xf.depth;
			fwd_data_s5 <= wr_data;
		end
	end

	assign cur       = fwd_hit_s5 ? fwd_data_s5 : rd_data;
	assign cur_mark  = cur[pzb_pkg::PIX_W-1];
	assign cur_depth = cur[DW-1:0];
	assign store     = (op_s5 == pzb_pkg::OP_PROJECT) && in_rng_s5
		&& (!cur_mark || (depth_s5 > cur_depth));
	assign wr_en     = adv && vld_s5 && store;
	assign wr_data   = {1'b1, depth_s5};
	assign sweep_start = adv && vld_s5 && (op_s5 == pzb_pkg::OP_CLEAR);

	pzb_pixel_mem #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (adv),
		.rd_addr     (addr_c),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (addr_s5),
		.wr_data     (wr_data),
		.sweep_start (sweep_start),
		.busy        (busy)
	);

	// A clear holds off new beats from its acceptance until its sweep is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_pend_q <= 1'b0;
		end else if (sweep_start) begin
			clr_pend_q <= 1'b0;
		end else if (accept && (cmd.op == pzb_pkg::OP_CLEAR)) begin
			clr_pend_q <= 1'b1;
		end
	end

	logic rd_hit;
	assign rd_hit = (op_s5 == pzb_pkg::OP_READ) && in_rng_s5 && cur_mark;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stored_q  <= store;
			hit_col_q <= store ? col_s5 : 8'd0;
			hit_row_q <= store ? row_s5 : 8'd0;
			marked_q  <= rd_hit;
			pdepth_q  <= rd_hit ? cur_depth : '0;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.stored       = stored_q;
	assign rsp.hit_col      = hit_col_q;
	assign rsp.hit_row      = hit_row_q;
	assign rsp.pixel_marked = marked_q;
	assign rsp.pixel_depth  = pdepth_q;

endmodule

// ===== verif/point_zbuffer_projection_tb.sv =====
module point_zbuffer_projection_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int ONE = 65536;
	localparam int STALL_LIMIT = 200000;
	localparam int ITEMS_PER_SETTING = 190;

	typedef struct {
		logic               stored;
		logic [7:0]         hit_col;
		logic [7:0]         hit_row;
		logic               marked;
		logic signed [19:0] depth;
	} zb_result_t;

	class zbuf_scoreboard;
		logic [53:0]        coef[3];
		logic [7:0]         ctr_col;
		logic [7:0]         ctr_row;
		logic [8:0]         plane_w;
		logic [8:0]         plane_h;
		bit                 mark_of[65536];
		bit signed [19:0]   depth_of[65536];
		bit                 ever_of[65536];
		int                 hit_list[$];
		zb_result_t         rsp_due[$];
		int                 errors;
		int                 n_cmds;
		int                 n_proj;
		int                 n_stored;
		int                 n_marked_reads;
		int                 n_clears;
		int                 n_rsps;

		function new();
			coef[0] = '0;
			coef[1] = '0;
			coef[2] = '0;
			ctr_col = pzb_pkg::CENTER_COL_RST;
			ctr_row = pzb_pkg::CENTER_ROW_RST;
			plane_w = pzb_pkg::PLANE_WIDTH_RST;
			plane_h = pzb_pkg::PLANE_HEIGHT_RST;
		endfunction

		function void set_reg(pzb_pkg::cfg_idx_t idx, logic [53:0] v);
			case (idx)
				pzb_pkg::CFG_ROW0:     coef[0] = v;
				pzb_pkg::CFG_ROW1:     coef[1] = v;
				pzb_pkg::CFG_ROW2:     coef[2] = v;
				pzb_pkg::CFG_CENTER_C: ctr_col = v[7:0];
				pzb_pkg::CFG_CENTER_R: ctr_row = v[7:0];
				pzb_pkg::CFG_PLANE_W:  plane_w = v[8:0];
				pzb_pkg::CFG_PLANE_H:  plane_h = v[8:0];
				default: ;
			endcase
		endfunction

		function int eff_w();
			return (plane_w > 9'd256) ? 256 : int'(plane_w);
		endfunction

		function int eff_h();
			return (plane_h > 9'd256) ? 256 : int'(plane_h);
		endfunction

		// Exact dot product with 20 fraction bits.
		static function longint dot3(logic [53:0] r, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z);
			logic signed [17:0] c0;
			logic signed [17:0] c1;
			logic signed [17:0] c2;
			c0 = r[17:0];
			c1 = r[35:18];
			c2 = r[53:36];
			return longint'(c0) * longint'(x) + longint'(c1) * longint'(y)
				+ longint'(c2) * longint'(z);
		endfunction

		// Divide by 2**k, rounding to nearest with ties going to the even quotient.
		static function longint round_even(longint v, int k);
			longint q;
			longint rem;
			longint half;
			q = v >>> k;
			rem = v - (q <<< k);
			half = longint'(1) <<< (k - 1);
			if (rem > half || (rem == half && q[0]))
				q = q + 1;
			return q;
		endfunction

		function void take_cmd(logic [1:0] op, logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic [7:0] rr, logic [7:0] rc);
			zb_result_t e;
			longint col;
			longint row;
			longint d;
			int w;
			int h;
			int idx;
			e = '{default: 0};
			w = eff_w();
			h = eff_h();
			n_cmds++;
			case (op)
				pzb_pkg::OP_CLEAR: begin
					foreach (mark_of[i])
						mark_of[i] = 1'b0;
					n_clears++;
				end
				pzb_pkg::OP_PROJECT: begin
					n_proj++;
					col = longint'(ctr_col) + round_even(dot3(coef[0], x, y, z), 20);
					row = longint'(ctr_row) - round_even(dot3(coef[1], x, y, z), 20);
					d = round_even(dot3(coef[2], x, y, z), 16);
					if (d > 524287)
						d = 524287;
					if (d < -524288)
						d = -524288;
					if (col >= 0 && col < w && row >= 0 && row < h) begin
						idx = int'(row) * pzb_pkg::MAX_COLS_DEF + int'(col);
						if (!mark_of[idx] || d > longint'(depth_of[idx])) begin
							depth_of[idx] = d[19:0];
							mark_of[idx] = 1'b1;
							if (!ever_of[idx]) begin
								ever_of[idx] = 1'b1;
								hit_list.insert(hit_list.size(), idx);
							end
							e.stored = 1'b1;
							e.hit_col = col[7:0];
							e.hit_row = row[7:0];
							n_stored++;
						end
					end
				end
				pzb_pkg::OP_READ: begin
					if (rr < h && rc < w) begin
						idx = int'(rr) * pzb_pkg::MAX_COLS_DEF + int'(rc);
						if (mark_of[idx]) begin
							e.marked = 1'b1;
							e.depth = depth_of[idx];
							n_marked_reads++;
						end
					end
				end
				default: ;
			endcase
			rsp_due.insert(rsp_due.size(), e);
		endfunction

		task flag(string what);
			errors++;
			$display("ERROR at %0t: %s", $time, what);
		endtask

		task check_rsp(logic stored, logic [7:0] hit_col, logic [7:0] hit_row,
			logic marked, logic signed [19:0] depth);
			zb_result_t e;
			n_rsps++;
			if (rsp_due.size() == 0) begin
				flag($sformatf("result %0d arrived with nothing outstanding", n_rsps));
				return;
			end
			e = rsp_due.pop_front();
			if (stored !== e.stored)
				flag($sformatf("result %0d: stored %b, want %b", n_rsps, stored, e.stored));
			if (hit_col !== e.hit_col)
				flag($sformatf("result %0d: hit_col %0d, want %0d", n_rsps, hit_col,
					e.hit_col));
			if (hit_row !== e.hit_row)
				flag($sformatf("result %0d: hit_row %0d, want %0d", n_rsps, hit_row,
					e.hit_row));
			if (marked !== e.marked)
				flag($sformatf("result %0d: pixel_marked %b, want %b", n_rsps, marked,
					e.marked));
			if (depth !== e.depth)
				flag($sformatf("result %0d: pixel_depth %0d, want %0d", n_rsps, depth,
					e.depth));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	pzb_pkg::cfg_idx_t cfg_idx;
	logic [pzb_pkg::ROWC_W-1:0] cfg_data;

	pzb_cmd_if cmd();
	pzb_rsp_if rsp();

	zbuf_scoreboard sb = new();

	int send_idle_pct;
	int rsp_stall_pct;
	bit hold_pending;
	int clears_left;
	int quiet_cycles;

	point_zbuffer_projection u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Response side: random stalls, plus one long hold-off on request.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp.ready = 1'b0;
				repeat (300) @(negedge clk);
			end else begin
				rsp.ready = ($urandom_range(0, 99) >= rsp_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd.valid && cmd.ready)
				sb.take_cmd(cmd.op, cmd.pt_x, cmd.pt_y, cmd.pt_z, cmd.read_row, cmd.read_col);
			if (rsp.valid && rsp.ready)
				sb.check_rsp(rsp.stored, rsp.hit_col, rsp.hit_row, rsp.pixel_marked,
					rsp.pixel_depth);
			if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic drive_cmd(logic [1:0] op, logic signed [15:0] x, logic signed [15:0] y,
		logic signed [15:0] z, logic [7:0] rr, logic [7:0] rc);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd.valid = 1'b0;
			@(negedge clk);
		end
		cmd.valid = 1'b1;
		cmd.op = op;
		cmd.pt_x = x;
		cmd.pt_y = y;
		cmd.pt_z = z;
		cmd.read_row = rr;
		cmd.read_col = rc;
		do
			@(posedge clk);
		while (!cmd.ready);
		@(negedge clk);
	endtask

	task automatic drive_plain(logic [1:0] op);
		drive_cmd(op, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	task automatic put_point(int x, int y, int z);
		drive_cmd(pzb_pkg::OP_PROJECT, x[15:0], y[15:0], z[15:0], 8'($urandom),
			8'($urandom));
	endtask

	task automatic read_pixel(int r, int c);
		drive_cmd(pzb_pkg::OP_READ, 16'($urandom), 16'($urandom), 16'($urandom), r[7:0],
			c[7:0]);
	endtask

	task automatic write_reg(pzb_pkg::cfg_idx_t idx, logic [53:0] v);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = v;
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Returns on a falling edge with nothing in flight and the clear sweep finished.
	task automatic wait_drained();
		cmd.valid = 1'b0;
		while (sb.rsp_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [53:0] pack3(int c0, int c1, int c2);
		return {c2[17:0], c1[17:0], c0[17:0]};
	endfunction

	function automatic int rand_coef(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic apply_setting(int k);
		logic [53:0] r0;
		logic [53:0] r1;
		logic [53:0] r2;
		int cc;
		int cr;
		int pw;
		int ph;
		case (k)
			0: begin
				r0 = pack3(ONE, 0, 0);
				r1 = pack3(0, ONE, 0);
				r2 = pack3(0, 0, ONE);
				cc = $urandom_range(100, 150);
				cr = $urandom_range(100, 150);
				pw = 256;
				ph = 256;
			end
			1: begin
				// Tiny plane, so points pile up on the same pixels.
				r0 = pack3(ONE / 4, ONE / 16, 0);
				r1 = pack3(-ONE / 16, ONE / 4, 0);
				r2 = pack3(ONE / 8, ONE / 8, ONE);
				cc = 8;
				cr = 8;
				pw = 16;
				ph = 16;
			end
			2: begin
				r0 = pack3(rand_coef(3 * ONE / 2), rand_coef(3 * ONE / 2), rand_coef(ONE));
				r1 = pack3(rand_coef(3 * ONE / 2), rand_coef(3 * ONE / 2), rand_coef(ONE));
				r2 = pack3(rand_coef(ONE), rand_coef(ONE), rand_coef(3 * ONE / 2));
				cc = $urandom_range(0, 255);
				cr = $urandom_range(0, 255);
				pw = $urandom_range(1, 256);
				ph = $urandom_range(1, 256);
			end
			3: begin
				// Coefficient extremes, corner centers, width beyond the maximum.
				r0 = pack3(-131072, 131071, 0);
				r1 = pack3(131071, -131072, 0);
				r2 = pack3(-131072, 131071, -131072);
				cc = 0;
				cr = 255;
				pw = 511;
				ph = 256;
			end
			4: begin
				r0 = pack3(rand_coef(ONE), rand_coef(ONE), 0);
				r1 = pack3(rand_coef(ONE), rand_coef(ONE), 0);
				r2 = pack3(0, 0, ONE);
				cc = $urandom_range(0, 255);
				cr = $urandom_range(0, 255);
				pw = 0;
				ph = 256;
			end
			5: begin
				r0 = pack3(ONE / 32, -ONE / 32, 0);
				r1 = pack3(ONE / 32, ONE / 32, 0);
				r2 = pack3(rand_coef(ONE), rand_coef(ONE), rand_coef(2 * ONE));
				cc = 0;
				cr = 0;
				pw = 1;
				ph = 1;
			end
			6: begin
				r0 = 54'({$urandom, $urandom});
				r1 = 54'({$urandom, $urandom});
				r2 = 54'({$urandom, $urandom});
				cc = $urandom_range(0, 255);
				cr = $urandom_range(0, 255);
				pw = $urandom_range(0, 511);
				ph = $urandom_range(0, 511);
			end
			default: begin
				r0 = pack3(ONE, 0, 0);
				r1 = pack3(0, ONE, 0);
				r2 = pack3(0, 0, -ONE);
				cc = 255;
				cr = 255;
				pw = 256;
				ph = 511;
			end
		endcase
		write_reg(pzb_pkg::CFG_ROW0, r0);
		write_reg(pzb_pkg::CFG_ROW1, r1);
		write_reg(pzb_pkg::CFG_ROW2, r2);
		write_reg(pzb_pkg::CFG_CENTER_C, 54'(cc));
		write_reg(pzb_pkg::CFG_CENTER_R, 54'(cr));
		write_reg(pzb_pkg::CFG_PLANE_W, 54'(pw));
		write_reg(pzb_pkg::CFG_PLANE_H, 54'(ph));
	endtask

	task automatic random_item();
		int r;
		int span;
		int idx;
		bit unwritten;
		logic [1:0] op;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [7:0] rr;
		logic [7:0] rc;
		x = 16'($urandom);
		y = 16'($urandom);
		z = 16'($urandom);
		rr = 8'($urandom);
		rc = 8'($urandom);
		r = $urandom_range(0, 99);
		if (clears_left > 0 && $urandom_range(0, 199) == 0) begin
			op = pzb_pkg::OP_CLEAR;
			clears_left--;
		end else if (r < 4) begin
			op = OP_NOP;
		end else if (r < 24) begin
			op = pzb_pkg::OP_READ;
		end else begin
			op = pzb_pkg::OP_PROJECT;
		end
		// Most points are kept near the origin so that they land on the plane.
		if (op == pzb_pkg::OP_PROJECT && $urandom_range(0, 9) > 1) begin
			case ($urandom_range(0, 2))
				0: span = 64;
				1: span = 512;
				default: span = 2048;
			endcase
			x = 16'(int'($urandom_range(0, 2 * span)) - span);
			y = 16'(int'($urandom_range(0, 2 * span)) - span);
		end
		if (op == pzb_pkg::OP_READ) begin
			// Never read an in-range pixel whose depth has not been written at some point.
			unwritten = (rr < sb.eff_h() && rc < sb.eff_w() && !sb.ever_of[{rr, rc}]);
			if (sb.hit_list.size() > 0 && (unwritten || $urandom_range(0, 9) < 6)) begin
				idx = sb.hit_list[$urandom_range(0, sb.hit_list.size() - 1)];
				rr = 8'(idx / pzb_pkg::MAX_COLS_DEF);
				rc = 8'(idx % pzb_pkg::MAX_COLS_DEF);
			end else if (unwritten) begin
				op = pzb_pkg::OP_PROJECT;
			end
		end
		drive_cmd(op, x, y, z, rr, rc);
	endtask

	initial begin
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.op = pzb_pkg::OP_CLEAR;
		cmd.pt_x = '0;
		cmd.pt_y = '0;
		cmd.pt_z = '0;
		cmd.read_row = '0;
		cmd.read_col = '0;
		cfg_we = 1'b0;
		cfg_idx = pzb_pkg::CFG_ROW0;
		cfg_data = '0;
		send_idle_pct = 20;
		rsp_stall_pct = 20;
		hold_pending = 1'b0;
		clears_left = 2;
		quiet_cycles = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: all coefficients zero, every point hits the center pixel.
		put_point(0, 0, 0);
		put_point(100, -50, 5);
		read_pixel(101, 114);

		wait_drained();
		write_reg(pzb_pkg::CFG_ROW0, pack3(ONE, 0, 0));
		write_reg(pzb_pkg::CFG_ROW1, pack3(0, ONE, 0));
		write_reg(pzb_pkg::CFG_ROW2, pack3(0, 0, ONE));
		// Half-unit offsets exercise rounding ties in both directions.
		put_point(8, 24, 100);
		put_point(-8, -24, -32768);
		put_point(24, -8, 32767);
		// Lower, equal and higher depth on an occupied pixel.
		put_point(0, 0, -16);
		put_point(0, 0, 0);
		put_point(0, 0, 16);
		put_point(32767, 32767, 0);
		put_point(-32768, -32768, 0);
		// Plane edges, just inside and just outside.
		put_point(1824, 1616, 5);
		put_point(1840, 0, 5);
		put_point(0, 1632, 5);
		put_point(-1824, -1616, 5);
		put_point(0, -1632, 5);
		put_point(-1840, 0, 5);
		read_pixel(99, 114);
		read_pixel(103, 114);
		read_pixel(255, 255);
		read_pixel(0, 228);
		drive_plain(pzb_pkg::OP_CLEAR);
		read_pixel(99, 114);
		put_point(8, 24, -5);
		read_pixel(99, 114);
		drive_plain(OP_NOP);

		for (int k = 0; k < 8; k++) begin
			wait_drained();
			apply_setting(k);
			case (k % 4)
				0: begin
					send_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 83;
					rsp_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					rsp_stall_pct = 83;
				end
				default: begin
					send_idle_pct = 20;
					rsp_stall_pct = 20;
				end
			endcase
			if (k % 2 == 0)
				drive_plain(pzb_pkg::OP_CLEAR);
			// Hold the response side once the sweep is over, so points back up.
			if (k == 0) begin
				wait_drained();
				hold_pending = 1'b1;
			end
			repeat (ITEMS_PER_SETTING) random_item();
		end

		cmd.valid = 1'b0;
		while (sb.rsp_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d commands: %0d projections (%0d stored), %0d reads of marked pixels,",
			sb.n_cmds, sb.n_proj, sb.n_stored, sb.n_marked_reads);
		$display("%0d clears, over eight register settings and four idle/stall patterns.",
			sb.n_clears);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
